// ===== src/box_blur_3x3_edge_average_defines.svh =====
// Assertion macros for the 3x3 box blur block.
// No dependencies; taken in by the RTL files that assert.
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_DEFINES_SVH
`ifndef SYNTH
// plain check, held off while reset is high
`define BB3_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// check that cons holds in the cycle after ante
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BB3_ASSERT(label, prop, msg)
`define BB3_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/bb3_pkg.sv =====
// Shared types, constants and the rounding divider of the 3x3 box blur.
// No dependencies.
package bb3_pkg;

   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int FRAME_WIDTH_RST  = 640;
   localparam int FRAME_HEIGHT_RST = 480;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // request kinds carried on req_tuser
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam int SUM_W   = 12;   // nine 8-bit taps
   localparam int CNT_W   = 4;    // tap count, up to nine
   localparam int FIFO_D  = 4;
   localparam int FIFO_AW = 2;

   // reciprocals: y/3 exact for y < 2048, y/9 exact for y < 32768
   localparam logic [11:0] RECIP3   = 12'd683;
   localparam int          RECIP3_SH = 11;
   localparam logic [11:0] RECIP9   = 12'd3641;
   localparam int          RECIP9_SH = 15;

   // red in the low byte
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // control carried with an item from acceptance into the window stage
   typedef struct packed {
      logic has_out;
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } item_ctl_type;

   typedef struct packed {
      logic      last;
      pixel_type pix;
   } result_type;

   // (2*sum + n) / (2*n), n in {1,2,3,4,6,9}
   function automatic logic [7:0] round_mean(input logic [SUM_W-1:0] sum,
                                             input logic [CNT_W-1:0] n);
      logic [SUM_W:0]   x;
      logic [SUM_W-1:0] y;
      logic [23:0]      p;
      logic [7:0]       q;
      x = {sum, 1'b0} + (SUM_W+1)'(n);
      y = '0;
      p = '0;
      q = '0;
      case (n)
         4'd1: q = sum[7:0];
         4'd2: q = 8'(x >> 2);
         4'd4: q = 8'(x >> 3);
         4'd3: begin
            y = SUM_W'(x >> 1);
            p = 24'(y) * 24'(RECIP3);
            q = 8'(p >> RECIP3_SH);
         end
         4'd6: begin
            y = SUM_W'(x >> 2);
            p = 24'(y) * 24'(RECIP3);
            q = 8'(p >> RECIP3_SH);
         end
         4'd9: begin
            y = SUM_W'(x >> 1);
            p = 24'(y) * 24'(RECIP9);
            q = 8'(p >> RECIP9_SH);
         end
         default: q = '0;
      endcase
      return q;
   endfunction

endpackage

// ===== src/box_blur_3x3_edge_average.sv =====
// 3x3 box blur with edge-aware averaging, top level.
// Depends on bb3_pkg and box_blur_3x3_edge_average_defines.svh.
//
// Usage:
//  - req_* carries one request per accepted beat: a pixel (tuser = 0) or a
//    flush tick (tuser = 1). Pixels arrive in raster order; after the last
//    pixel of a frame, width+1 flush ticks (or any requests) drain the last
//    row. Flush ticks during the pixel phase are dropped.
//  - rsp_* returns blurred pixels in raster order, tlast on the last one of
//    the frame. Output k appears for the request at stream position k+W+1.
//  - csr_* writes frame_width (index 0) and frame_height (index 1). A write to
//    either of them restarts the frame. Write only while the block is idle.
// Throughput: one request per clock. Each request reads both line stores at
//  its column and writes them back in the next cycle; back-to-back requests
//  at the same column (width 1) take the written data from a bypass.
// Result path: line store read, window sum, divide, then the output queue;
//  rsp_tvalid is high while the queue holds a result.
// Reset: width 640, height 480, position zero. Line stores are not cleared;
//  any entry read before it is written lies outside the frame and is masked.
// Stall: results go into a 4-deep output queue; req_tready falls only when
//  results in flight plus queued reach four, so a stalled receiver does not
//  block the input side until the queue fills.
`include "box_blur_3x3_edge_average_defines.svh"

module box_blur_3x3_edge_average #(
   parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,   // red_in, green_in, blue_in
   input  logic                           req_tuser,   // command
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // red_out, green_out, blue_out
   output logic                           rsp_tlast,   // frame_end
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column address
   localparam int WW = $clog2(MAX_WIDTH + 1);                     // width value
   localparam int RW = 17;                                        // row, incl. drain
   localparam int RST_W = (bb3_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                          MAX_WIDTH : bb3_pkg::FRAME_WIDTH_RST;

   // ---------------- configuration ----------------
   logic [WW-1:0] width_ff, width_in;
   logic [15:0]   height_ff, height_in;
   logic          restart;
   logic [10:0]   w_raw;

   assign csr_ready = 1'b1;
   assign w_raw     = csr_data[10:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            bb3_pkg::CSR_FRAME_WIDTH: begin
               restart = 1'b1;
               if (w_raw == 11'd0) begin
                  width_in = WW'(1);
               end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(w_raw);
               end
            end
            bb3_pkg::CSR_FRAME_HEIGHT: begin
               restart   = 1'b1;
               height_in = (csr_data == 16'd0) ? 16'd1 : csr_data;
            end
            default: restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(RST_W);
         height_ff <= 16'(bb3_pkg::FRAME_HEIGHT_RST);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------- acceptance and position ----------------
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] h_ext;
   logic [WW-1:0] col_p1;
   logic          req_fire, drain, work, pre, post;
   bb3_pkg::item_ctl_type ctl;
   bb3_pkg::pixel_type    px;
   logic [2:0]    inflight;

   logic                  s1_valid_ff;
   logic [CW-1:0]         s1_addr_ff;
   bb3_pkg::pixel_type    s1_px_ff;
   bb3_pkg::item_ctl_type s1_ctl_ff;
   logic                  fwd_ff;
   logic                  s2_valid_ff;
   logic [2:0]            cnt_ff, cnt_in;

   assign inflight   = 3'(s1_valid_ff & s1_ctl_ff.has_out) + 3'(s2_valid_ff) + cnt_ff;
   assign req_tready = (inflight < 3'(bb3_pkg::FIFO_D));
   assign req_fire   = req_tvalid & req_tready;

   assign h_ext  = RW'(height_ff);
   assign drain  = (row_ff >= h_ext);
   assign work   = req_fire & (drain | (req_tuser == bb3_pkg::CMD_PIXEL));
   assign pre    = (col_ff == '0) && (row_ff >= RW'(2));
   assign post   = (col_ff != '0) && (row_ff >= RW'(1));
   assign col_p1 = WW'(col_ff) + WW'(1);
   assign px     = drain ? '0 : bb3_pkg::pixel_type'(req_tdata);

   always_comb begin
      // pre: last column of row r-2, taken before the shift
      // post: column c-1 of row r-1, taken after the shift
      ctl.has_out = pre | post;
      ctl.top     = pre ? (row_ff >= RW'(3)) : (row_ff >= RW'(2));
      ctl.bottom  = pre ? (row_ff <= h_ext) : (row_ff < h_ext);
      ctl.left    = pre ? (width_ff >= WW'(2)) : (col_ff >= CW'(2));
      ctl.right   = post;
      ctl.last    = pre && (row_ff == h_ext + RW'(1));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (work) begin
         if (ctl.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_p1 >= width_ff) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = CW'(col_p1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= work;
         // previous item writes this column in the same cycle as our read
         fwd_ff      <= work & s1_valid_ff & (s1_addr_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (work) begin
         s1_addr_ff <= col_ff;
         s1_px_ff   <= px;
         s1_ctl_ff  <= ctl;
      end
   end

   // ---------------- line stores ----------------
   bb3_pkg::pixel_type upper_mem  [MAX_WIDTH];
   bb3_pkg::pixel_type middle_mem [MAX_WIDTH];
   bb3_pkg::pixel_type upper_rd_ff, middle_rd_ff;
   bb3_pkg::pixel_type wr_upper_ff, wr_middle_ff;
   bb3_pkg::pixel_type up_col, mid_col;

   assign up_col  = fwd_ff ? wr_upper_ff  : upper_rd_ff;
   assign mid_col = fwd_ff ? wr_middle_ff : middle_rd_ff;

   always_ff @(posedge clock) begin
      if (work) begin
         upper_rd_ff  <= upper_mem[col_ff];
         middle_rd_ff <= middle_mem[col_ff];
      end
      if (s1_valid_ff) begin
         upper_mem[s1_addr_ff]  <= mid_col;
         middle_mem[s1_addr_ff] <= s1_px_ff;
         wr_upper_ff            <= mid_col;
         wr_middle_ff           <= s1_px_ff;
      end
   end

   // ---------------- window and masked sums ----------------
   // win_ff[row][0] is the left tap, [row][1] the centre; the right tap is the
   // column arriving from the line stores, or the new pixel for the bottom row.
   bb3_pkg::pixel_type win_ff [3][2];
   bb3_pkg::pixel_type newcol [3];
   logic [bb3_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;
   logic [1:0] nrows, ncols;
   logic [bb3_pkg::CNT_W-1:0] ntaps;
   logic row_on [3];

   assign newcol[0] = up_col;
   assign newcol[1] = mid_col;
   assign newcol[2] = s1_px_ff;
   assign row_on[0] = s1_ctl_ff.top;
   assign row_on[1] = 1'b1;
   assign row_on[2] = s1_ctl_ff.bottom;

   always_comb begin
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int i = 0; i < 3; i++) begin
         if (row_on[i]) begin
            sum_r = sum_r + bb3_pkg::SUM_W'(win_ff[i][1].red);
            sum_g = sum_g + bb3_pkg::SUM_W'(win_ff[i][1].green);
            sum_b = sum_b + bb3_pkg::SUM_W'(win_ff[i][1].blue);
            if (s1_ctl_ff.left) begin
               sum_r = sum_r + bb3_pkg::SUM_W'(win_ff[i][0].red);
               sum_g = sum_g + bb3_pkg::SUM_W'(win_ff[i][0].green);
               sum_b = sum_b + bb3_pkg::SUM_W'(win_ff[i][0].blue);
            end
            if (s1_ctl_ff.right) begin
               sum_r = sum_r + bb3_pkg::SUM_W'(newcol[i].red);
               sum_g = sum_g + bb3_pkg::SUM_W'(newcol[i].green);
               sum_b = sum_b + bb3_pkg::SUM_W'(newcol[i].blue);
            end
         end
      end
   end

   assign nrows = 2'd1 + 2'(s1_ctl_ff.top) + 2'(s1_ctl_ff.bottom);
   assign ncols = 2'd1 + 2'(s1_ctl_ff.left) + 2'(s1_ctl_ff.right);
   assign ntaps = bb3_pkg::CNT_W'(nrows) * bb3_pkg::CNT_W'(ncols);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= '0;
            win_ff[i][1] <= '0;
         end
      end else if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= s1_ctl_ff.last ? '0 : win_ff[i][1];
            win_ff[i][1] <= s1_ctl_ff.last ? '0 : newcol[i];
         end
      end
   end

   // ---------------- divide stage ----------------
   logic [bb3_pkg::SUM_W-1:0] s2_sum_r_ff, s2_sum_g_ff, s2_sum_b_ff;
   logic [bb3_pkg::CNT_W-1:0] s2_n_ff;
   logic                      s2_last_ff;
   bb3_pkg::result_type       s2_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff & s1_ctl_ff.has_out;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff & s1_ctl_ff.has_out) begin
         s2_sum_r_ff <= sum_r;
         s2_sum_g_ff <= sum_g;
         s2_sum_b_ff <= sum_b;
         s2_n_ff     <= ntaps;
         s2_last_ff  <= s1_ctl_ff.last;
      end
   end

   assign s2_res.last      = s2_last_ff;
   assign s2_res.pix.red   = bb3_pkg::round_mean(s2_sum_r_ff, s2_n_ff);
   assign s2_res.pix.green = bb3_pkg::round_mean(s2_sum_g_ff, s2_n_ff);
   assign s2_res.pix.blue  = bb3_pkg::round_mean(s2_sum_b_ff, s2_n_ff);

   // ---------------- output queue ----------------
   bb3_pkg::result_type fifo_ff [bb3_pkg::FIFO_D];
   logic [bb3_pkg::FIFO_AW-1:0] wp_ff, rp_ff;
   logic rsp_fire;
   bb3_pkg::result_type head;

   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign head       = fifo_ff[rp_ff];
   assign rsp_tdata  = head.pix;
   assign rsp_tlast  = head.last;
   assign cnt_in     = cnt_ff + 3'(s2_valid_ff) - 3'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (s2_valid_ff) begin
            wp_ff <= wp_ff + bb3_pkg::FIFO_AW'(1);
         end
         if (rsp_fire) begin
            rp_ff <= rp_ff + bb3_pkg::FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         fifo_ff[wp_ff] <= s2_res;
      end
   end

   // ---------------- checks ----------------
   `BB3_ASSERT(a_credit_bound, inflight <= 3'(bb3_pkg::FIFO_D), "results in flight exceed queue depth")
   `BB3_ASSERT(a_fwd_needs_item, !fwd_ff || s1_valid_ff, "bypass with no item in window stage")
   `BB3_ASSERT(a_col_in_frame, WW'(col_ff) < width_ff, "column position outside frame width")
   `BB3_ASSERT_NEXT(a_queue_filled, s2_valid_ff, cnt_ff != 3'd0, "divided result not queued")

endmodule

// ===== verif/tb_box_blur_3x3_edge_average.sv =====
// Self-checking testbench for the 3x3 box blur: random frames, random stalls,
// results checked against a built-in predictor of the blur.
// Depends on bb3_pkg and on the box_blur_3x3_edge_average top level.
module tb_box_blur_3x3_edge_average;

   localparam int MAX_W        = bb3_pkg::MAX_WIDTH_DEF;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 2000;
   localparam int SETTLE       = 8;      // pipeline is 3 deep, leave margin
   localparam logic [bb3_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // no register there

   typedef struct {
      logic               cmd;
      bb3_pkg::pixel_type pix;
   } request_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [23:0]                    req_tdata = '0;   // red_in, green_in, blue_in
   logic                           req_tuser = 1'b0; // command
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [23:0]                    rsp_tdata;        // red_out, green_out, blue_out
   logic                           rsp_tlast;        // frame_end
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [bb3_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bb3_pkg::CSR_DATA_W-1:0] csr_data = '0;

   box_blur_3x3_edge_average dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: line stores, window, stream position, frame size
   // ---------------------------------------------------------------------
   bb3_pkg::pixel_type upper_row [MAX_W];
   bb3_pkg::pixel_type middle_row [MAX_W];
   bb3_pkg::pixel_type win [9];          // [row*3 + col], col 0 oldest
   int          pos_col, pos_row;
   logic [10:0] width_reg;
   logic [15:0] height_reg;

   bb3_pkg::result_type blur_expected [$];
   request_type pending_requests [$];
   request_type cur_req;
   int          errors = 0;
   int          results_seen = 0;
   int          requests_taken = 0;
   int          frames_seen = 0;
   int          cycles = 0;

   function automatic int active_width();
      int w;
      w = int'(width_reg);
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int active_height();
      return (height_reg == 0) ? 1 : int'(height_reg);
   endfunction

   function automatic void restart_frame();
      pos_col = 0;
      pos_row = 0;
      foreach (win[i]) win[i] = '0;
   endfunction

   // Mean of the in-frame taps around window column ctr, rounded half up.
   function automatic bb3_pkg::pixel_type window_mean(int ctr, bit top, bit bot, bit lft,
                                                      bit rgt);
      int sr, sg, sb, n, c;
      bb3_pkg::pixel_type q;
      sr = 0; sg = 0; sb = 0; n = 0;
      for (int i = 0; i < 3; i++) begin
         if ((i == 0 && !top) || (i == 2 && !bot)) continue;
         for (int k = 0; k < 3; k++) begin
            if ((k == 0 && !lft) || (k == 2 && !rgt)) continue;
            c = ctr + k - 1;
            if (c > 2) continue;
            sr += win[i*3+c].red;
            sg += win[i*3+c].green;
            sb += win[i*3+c].blue;
            n++;
         end
      end
      q.red   = 8'((2*sr + n) / (2*n));
      q.green = 8'((2*sg + n) / (2*n));
      q.blue  = 8'((2*sb + n) / (2*n));
      return q;
   endfunction

   function automatic void blur_step(request_type rq);
      int w, h, orow, ocol;
      bit got, drain;
      bb3_pkg::pixel_type px, res;
      bb3_pkg::result_type e;
      w = active_width();
      h = active_height();
      drain = pos_row >= h;
      got = 0;
      orow = 0;
      ocol = 0;
      res = '0;
      if (!drain && rq.cmd == bb3_pkg::CMD_FLUSH) return;   // flush inside a frame is dropped
      px = drain ? bb3_pkg::pixel_type'('0) : rq.pix;
      // first column of a row closes the last pixel of the row two back
      if (pos_col == 0 && pos_row >= 2) begin
         orow = pos_row - 2;
         ocol = w - 1;
         res = window_mean(2, orow >= 1, orow + 1 < h, w >= 2, 0);
         got = 1;
      end
      for (int i = 0; i < 3; i++) begin
         win[i*3]   = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = upper_row[pos_col];
      win[5] = middle_row[pos_col];
      win[8] = px;
      upper_row[pos_col]  = middle_row[pos_col];
      middle_row[pos_col] = px;
      if (pos_col >= 1 && pos_row >= 1) begin
         orow = pos_row - 1;
         ocol = pos_col - 1;
         res = window_mean(1, orow >= 1, orow + 1 < h, ocol >= 1, 1);
         got = 1;
      end
      pos_col++;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
      end
      if (got) begin
         e.pix  = res;
         e.last = (orow == h - 1) && (ocol == w - 1);
         blur_expected.push_back(e);
         if (e.last) restart_frame();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps
   // ---------------------------------------------------------------------
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      logic nv;
      nv = req_tvalid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            blur_step(cur_req);
            requests_taken++;
            nv = 1'b0;
         end
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               cur_req = pending_requests.pop_front();
               nv = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  // some stretches run back to back
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_tvalid <= nv;
         if (nv) begin
            req_tdata <= cur_req.pix;
            req_tuser <= cur_req.cmd;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result receiver: stalls on its own pattern, plus long hold-offs on demand
   // ---------------------------------------------------------------------
   int hold_kicks = 0;    // bumped by the stimulus to ask for a long hold-off
   int hold_taken = 0;
   int hold_left = 0;
   int stall_phase = 0;

   always @(posedge clock) begin
      logic rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_phase = (stall_phase + 1) % 512;
         if (hold_taken != hold_kicks) begin
            hold_taken = hold_kicks;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (stall_phase < 128) begin
            rdy = 1'b1;               // calm stretch, no stalls
         end else begin
            rdy = ($urandom_range(0, 3) != 0);
         end
         rsp_tready <= rdy;
      end
   end

   // result checker
   always @(posedge clock) begin
      bb3_pkg::result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (blur_expected.size() == 0) begin
            $error("result with no pending expectation: data %h last %b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            e = blur_expected.pop_front();
            if (rsp_tdata[7:0] !== e.pix.red) begin
               $error("red_out: expected %0d, got %0d", e.pix.red, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[15:8] !== e.pix.green) begin
               $error("green_out: expected %0d, got %0d", e.pix.green, rsp_tdata[15:8]);
               errors++;
            end
            if (rsp_tdata[23:16] !== e.pix.blue) begin
               $error("blue_out: expected %0d, got %0d", e.pix.blue, rsp_tdata[23:16]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("frame_end: expected %0d, got %0d", e.last, rsp_tlast);
               errors++;
            end
            if (e.last) frames_seen++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  blur_expected.size());
         $display("[box_blur_3x3_edge_average] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic bb3_pkg::pixel_type rand_pixel();
      bb3_pkg::pixel_type p;
      p = bb3_pkg::pixel_type'(24'($urandom_range(0, 24'hFFFFFF)));
      return p;
   endfunction

   function automatic void queue_request(logic cmd, bb3_pkg::pixel_type p);
      request_type rq;
      rq.cmd = cmd;
      rq.pix = p;
      pending_requests.push_back(rq);
   endfunction

   // wait until the block has drained everything we know about
   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_tvalid || blur_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [bb3_pkg::CSR_IDX_W-1:0] idx,
                            logic [bb3_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == bb3_pkg::CSR_FRAME_WIDTH) begin
         width_reg = val[10:0];
         restart_frame();
      end else if (idx == bb3_pkg::CSR_FRAME_HEIGHT) begin
         height_reg = val;
         restart_frame();
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(int w, int h);
      // width register is 11 bits; junk in the upper data bits is dropped
      csr_write(bb3_pkg::CSR_FRAME_WIDTH, {5'($urandom_range(0, 31)), 11'(w)});
      csr_write(bb3_pkg::CSR_FRAME_HEIGHT, 16'(h));
   endtask

   // one frame of pixels plus its drain; returns the number of requests queued
   task automatic queue_frame(int stray_pct, output int n);
      int w, h;
      w = active_width();
      h = active_height();
      n = 0;
      for (int i = 0; i < w*h; i++) begin
         if ($urandom_range(0, 99) < stray_pct) begin
            queue_request(bb3_pkg::CMD_FLUSH, rand_pixel());
            n++;
         end
         queue_request(bb3_pkg::CMD_PIXEL, rand_pixel());
         n++;
      end
      // drain: flush ticks, sometimes pixels that stand in for them
      for (int i = 0; i <= w; i++) begin
         queue_request(($urandom_range(0, 3) == 0) ? bb3_pkg::CMD_PIXEL : bb3_pkg::CMD_FLUSH,
                       rand_pixel());
         n++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int done_items, n, w, h, frames;
      done_items = 0;
      width_reg  = 11'(bb3_pkg::FRAME_WIDTH_RST);
      height_reg = 16'(bb3_pkg::FRAME_HEIGHT_RST);
      restart_frame();
      foreach (upper_row[i]) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single pixel frame: divisor one, white pixel passes unchanged
      set_frame(1, 1);
      queue_request(bb3_pkg::CMD_PIXEL, bb3_pkg::pixel_type'(24'hFFFFFF));
      queue_request(bb3_pkg::CMD_FLUSH, '0);
      queue_request(bb3_pkg::CMD_PIXEL, bb3_pkg::pixel_type'(24'h123456));   // stands in as flush
      done_items += 3;
      wait_idle();

      // 3x3 checkerboard of black and white: corners, edges, interior,
      // with a stray flush inside the frame that must be dropped
      set_frame(3, 3);
      for (int i = 0; i < 9; i++) begin
         queue_request(bb3_pkg::CMD_PIXEL,
                       (i % 2) ? bb3_pkg::pixel_type'(24'hFFFFFF) : bb3_pkg::pixel_type'('0));
         if (i == 4) queue_request(bb3_pkg::CMD_FLUSH, bb3_pkg::pixel_type'(24'hFFFFFF));
      end
      for (int i = 0; i < 4; i++) queue_request(bb3_pkg::CMD_FLUSH, '0);
      done_items += 14;
      wait_idle();

      // a write to an index with no register behind it
      csr_write(CSR_SPARE, 16'hFFFF);

      // long receiver hold-off while the sender keeps pushing
      set_frame(8, 6);
      hold_kicks++;
      queue_frame(0, n);
      done_items += n;
      wait_idle();

      // extremes of the size registers
      set_frame(0, 0);                  // both act as one
      queue_frame(10, n);
      done_items += n;
      wait_idle();
      // clamps to the widest line; one full row, then part of its drain,
      // cut off by the next write
      set_frame(11'h7FF, 1);
      for (int i = 0; i < MAX_W; i++) queue_request(bb3_pkg::CMD_PIXEL, rand_pixel());
      for (int i = 0; i < 80; i++) queue_request(bb3_pkg::CMD_FLUSH, '0);
      done_items += MAX_W + 80;
      wait_idle();
      // tallest frame: abandoned after a few rows by the next write
      set_frame(2, 65535);
      for (int i = 0; i < 20; i++) queue_request(bb3_pkg::CMD_PIXEL, rand_pixel());
      done_items += 20;
      wait_idle();
      set_frame(1, 7);
      queue_frame(5, n);
      done_items += n;
      wait_idle();

      // random frames, mostly small and well formed
      while (done_items < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 10);
         set_frame(w, h);
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            queue_frame(5, n);
            done_items += n;
         end
         // now and then a cut-off frame, dropped by the next write
         if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, w*h);
            for (int i = 0; i < n; i++) queue_request(bb3_pkg::CMD_PIXEL, rand_pixel());
            done_items += n;
         end
         if ($urandom_range(0, 15) == 0) hold_kicks++;
         wait_idle();
      end

      wait_idle();
      if (blur_expected.size() != 0) begin
         $error("%0d expected results never arrived", blur_expected.size());
         errors++;
      end
      $display("covered %0d requests, %0d blurred pixels, %0d complete frames",
               requests_taken, results_seen, frames_seen);
      $display("frame sizes from 1x1 to %0d wide and 65535 tall, with stalls", MAX_W);
      if (errors == 0) begin
         $display("[box_blur_3x3_edge_average] OK");
      end else begin
         $display("[box_blur_3x3_edge_average] ERROR");
      end
      $finish;
   end

endmodule
